@@ rtl/lbbe_pkg.sv @@
// package for the linear byte buffer engine
// holds widths, request codes and the control struct shared by the cells
package lbbe_pkg;

  localparam int unsigned DEF_DEPTH  = 64;
  localparam int unsigned CNT_W      = 7;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned MAX_READ   = 64;
  localparam logic [6:0]  CAP_RESET  = 7'd64;

  typedef enum logic [3:0] {
    REQ_WRITE     = 4'd0,
    REQ_WRITE_REV = 4'd1,
    REQ_INSERT    = 4'd2,
    REQ_READ      = 4'd3,
    REQ_READ_AT   = 4'd4,
    REQ_TAKE_BACK = 4'd5,
    REQ_RESERVE   = 4'd6,
    REQ_FORCE     = 4'd7,
    REQ_FLUSH     = 4'd8
  } req_code_t;

  typedef struct packed {
    logic       shift;
    logic [8:0] shift_lo;
    logic [8:0] shift_hi;
    logic       keep;
    logic [8:0] keep_hi;
    logic       clr;
    logic [8:0] clr_lo;
    logic [8:0] clr_hi;
    logic       wr;
    logic [7:0] wr_idx;
    logic [7:0] wr_data;
  } cell_ctl_t;

endpackage

@@ rtl/lbbe_cell.sv @@
// one byte cell of the store chain
// depends on lbbe_pkg for the control struct
module lbbe_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic                clk,
  input  lbbe_pkg::cell_ctl_t ctl,
  input  logic [7:0]          prev_byte,
  output logic [7:0]          cell_byte
);
  import lbbe_pkg::*;

  logic [7:0] byte_r;
  logic [7:0] sav_r;
  logic [8:0] my_idx;

  assign my_idx    = 9'(IDX);
  assign cell_byte = byte_r;

  always_ff @(posedge clk) begin
    // byte from before the shift, given back to the cells under the insert gap
    if (!ctl.shift) sav_r <= byte_r;
    if (ctl.shift && my_idx >= ctl.shift_lo && my_idx <= ctl.shift_hi) begin
      byte_r <= (ctl.keep && my_idx <= ctl.keep_hi) ? sav_r : prev_byte;
    end else if (ctl.clr && my_idx >= ctl.clr_lo && my_idx < ctl.clr_hi) begin
      byte_r <= '0;
    end else if (ctl.wr && {1'b0, ctl.wr_idx} == my_idx) begin
      byte_r <= ctl.wr_data;
    end
  end
endmodule

@@ rtl/linear_byte_buffer_engine_core.sv @@
// top level of the linear byte buffer engine: command control and cell chain
// depends on lbbe_pkg and lbbe_cell
//
// Usage:
//  in_* carries request items (valid/ready). A write, reversed write or insert
//  streams one data byte per item and ends on the item with last_byte set,
//  which gives one status result. Other requests take a single item.
//  out_* gives results (valid/ready); a read gives one result per byte with
//  last_result on the final one. cfg_* writes the capacity register, taken
//  at any time (ready is always high), meant for idle periods.
//  A single-item status result shows in the cycle after its request; a
//  read's first byte passes S_READ and the output register, a one-item write
//  command's status S_DATA and the output register. Streamed bytes go one
//  per cycle while the output slot is free; the first item of a write command
//  passes through S_DATA, and an insert inside the data through S_SHIFT while
//  the cell chain shifts later bytes up one place per cycle. Reads give one
//  byte per cycle through the output register while the slot is free.
//  Reset clears fill count, read index and command state; store bytes stay
//  unknown until written. While the receiver stalls the output register
//  holds its result and no new request is taken.
module linear_byte_buffer_engine_core #(
  parameter int unsigned BUF_DEPTH = lbbe_pkg::DEF_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [3:0] in_req_type,
  input  logic [7:0] in_position,
  input  logic [7:0] in_length,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_status,
  output logic [7:0] out_data_out,
  output logic [6:0] out_start_index,
  output logic [6:0] out_fill_after,
  output logic       out_last_result,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [6:0] cfg_data
);
  import lbbe_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_SHIFT, S_DATA, S_READ} state_t;

  state_t     st_r, st_nxt;
  logic [6:0] cap_r;
  logic [6:0] fill_r, fill_nxt;
  logic [6:0] ri_r, ri_nxt;
  logic       act_r, act_nxt;
  logic [3:0] code_r, code_nxt;
  logic       acc_r, acc_nxt;
  logic [7:0] wi_r, wi_nxt;
  logic [7:0] bl_r, bl_nxt;
  logic [7:0] cnt_r, cnt_nxt;
  logic [7:0] pd_r, pd_nxt;
  logic       pl_r, pl_nxt;
  cell_ctl_t  ctl_r, ctl_nxt;

  logic       ov_r, os_r, ol_r;
  logic [7:0] od_r;
  logic [6:0] osi_r, ofa_r;

  logic       em, es, el;
  logic [7:0] ed;
  logic [6:0] esi;
  logic       slot_free, in_acc;
  cell_ctl_t  ctl;
  logic [7:0] cells [BUF_DEPTH];
  logic [7:0] rd_byte;

  logic [7:0] size8, room8, top8;
  logic [8:0] sum9;
  logic       do_data;
  logic [7:0] d_byte;
  logic       d_last;

  assign slot_free = !ov_r || out_ready;
  assign in_ready  = (st_r == S_IDLE) && slot_free;
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  assign out_valid       = ov_r;
  assign out_status      = os_r;
  assign out_data_out    = od_r;
  assign out_start_index = osi_r;
  assign out_fill_after  = ofa_r;
  assign out_last_result = ol_r;

  assign size8 = ({1'b0, cap_r} > 8'(BUF_DEPTH)) ? 8'(BUF_DEPTH) : {1'b0, cap_r};
  assign room8 = ({1'b0, fill_r} >= size8) ? 8'd0 : size8 - {1'b0, fill_r};

  // read mux over the cell row
  always_comb begin
    rd_byte = '0;
    for (int i = 0; i < BUF_DEPTH; i++) begin
      if (8'(i) == {1'b0, ri_r}) rd_byte = cells[i];
    end
  end

  always_comb begin
    st_nxt   = st_r;
    fill_nxt = fill_r;
    ri_nxt   = ri_r;
    act_nxt  = act_r;
    code_nxt = code_r;
    acc_nxt  = acc_r;
    wi_nxt   = wi_r;
    bl_nxt   = bl_r;
    cnt_nxt  = cnt_r;
    pd_nxt   = pd_r;
    pl_nxt   = pl_r;
    ctl_nxt  = ctl_r;
    ctl      = '0;
    em = 1'b0; es = 1'b0; el = 1'b1; ed = '0; esi = '0;
    top8 = '0; sum9 = '0;
    do_data = 1'b0; d_byte = in_data_byte; d_last = in_last_byte;

    unique case (st_r)
      S_IDLE: begin
        if (in_acc) begin
          if (act_r) begin
            do_data = 1'b1;
          end else begin
            priority case (in_req_type)
              REQ_WRITE, REQ_WRITE_REV, REQ_INSERT: begin
                act_nxt  = 1'b1;
                code_nxt = in_req_type;
                bl_nxt   = in_length;
                acc_nxt  = 1'b0;
                pd_nxt   = in_data_byte;
                pl_nxt   = in_last_byte;
                cnt_nxt  = '0;
                st_nxt   = S_DATA;
                if (in_req_type == REQ_INSERT) begin
                  top8 = (in_position > {1'b0, fill_r}) ? in_position : {1'b0, fill_r};
                  sum9 = {1'b0, in_length} + {1'b0, top8};
                  if (sum9 <= {1'b0, size8}) begin
                    acc_nxt = 1'b1;
                    wi_nxt  = in_position;
                    if (in_position < {1'b0, fill_r}) begin
                      fill_nxt = fill_r + in_length[6:0];
                      if (in_length != 8'd0) begin
                        // move later bytes up one place per cycle
                        cnt_nxt          = in_length;
                        ctl_nxt.shift_lo = {1'b0, in_position} + 9'd1;
                        ctl_nxt.shift_hi = {2'b0, fill_r} + {1'b0, in_length} - 9'd1;
                        ctl_nxt.keep_hi  = {1'b0, in_position} + {1'b0, in_length} - 9'd1;
                        st_nxt           = S_SHIFT;
                      end
                    end else begin
                      fill_nxt   = in_position[6:0] + in_length[6:0];
                      ctl.clr    = 1'b1;
                      ctl.clr_lo = {2'b0, fill_r};
                      ctl.clr_hi = {1'b0, in_position};
                    end
                  end
                end else if (in_length <= room8) begin
                  acc_nxt  = 1'b1;
                  wi_nxt   = (in_req_type == REQ_WRITE_REV) ?
                             {1'b0, fill_r} + in_length - 8'd1 : {1'b0, fill_r};
                  fill_nxt = fill_r + in_length[6:0];
                end
              end
              REQ_READ, REQ_READ_AT: begin
                top8 = (in_req_type == REQ_READ_AT) ? in_position : {1'b0, ri_r};
                sum9 = {1'b0, top8} + {1'b0, in_length};
                if (sum9 > {2'b0, fill_r} || in_length > 8'(MAX_READ)) begin
                  em = 1'b1; es = 1'b1;
                end else begin
                  ri_nxt = top8[6:0];
                  if (in_length == 8'd0) begin
                    em = 1'b1;
                  end else begin
                    cnt_nxt = in_length;
                    st_nxt  = S_READ;
                  end
                end
              end
              REQ_TAKE_BACK: begin
                fill_nxt = (in_length >= {1'b0, fill_r}) ? 7'd0 : fill_r - in_length[6:0];
                if (ri_r > fill_nxt) ri_nxt = fill_nxt;
                em = 1'b1;
              end
              REQ_RESERVE: begin
                em = 1'b1;
                if (in_length > room8) begin
                  es = 1'b1;
                end else begin
                  esi      = fill_r;
                  fill_nxt = fill_r + in_length[6:0];
                end
              end
              REQ_FORCE: begin
                em = 1'b1;
                if (in_position >= size8) es = 1'b1;
                else fill_nxt = in_position[6:0];
              end
              REQ_FLUSH: begin
                em = 1'b1;
                fill_nxt = '0;
                ri_nxt = '0;
              end
              default: begin
                em = 1'b1; es = 1'b1;
              end
            endcase
          end
        end
      end
      S_SHIFT: begin
        ctl.shift    = 1'b1;
        ctl.shift_lo = ctl_r.shift_lo;
        ctl.shift_hi = ctl_r.shift_hi;
        // last step: cells inside the gap take their own old bytes back
        ctl.keep     = (cnt_r == 8'd1);
        ctl.keep_hi  = ctl_r.keep_hi;
        cnt_nxt      = cnt_r - 8'd1;
        if (cnt_r == 8'd1) st_nxt = S_DATA;
      end
      S_DATA: begin
        if (slot_free) begin
          do_data = 1'b1;
          d_byte  = pd_r;
          d_last  = pl_r;
          st_nxt  = S_IDLE;
        end
      end
      S_READ: begin
        if (slot_free) begin
          em = 1'b1;
          ed = rd_byte;
          el = (cnt_r == 8'd1);
          ri_nxt  = ri_r + 7'd1;
          cnt_nxt = cnt_r - 8'd1;
          if (cnt_r == 8'd1) st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase

    if (do_data) begin
      if (acc_r && bl_r != 8'd0) begin
        ctl.wr      = 1'b1;
        ctl.wr_idx  = wi_r;
        ctl.wr_data = d_byte;
        wi_nxt = (code_r == REQ_WRITE_REV) ? wi_r - 8'd1 : wi_r + 8'd1;
        bl_nxt = bl_r - 8'd1;
      end
      if (d_last) begin
        em      = 1'b1;
        es      = !acc_r;
        act_nxt = 1'b0;
        acc_nxt = 1'b0;
        bl_nxt  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      cap_r  <= CAP_RESET;
      fill_r <= '0;
      ri_r   <= '0;
      act_r  <= 1'b0;
      code_r <= '0;
      acc_r  <= 1'b0;
      wi_r   <= '0;
      bl_r   <= '0;
      cnt_r  <= '0;
      ov_r   <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      fill_r <= fill_nxt;
      ri_r   <= ri_nxt;
      act_r  <= act_nxt;
      code_r <= code_nxt;
      acc_r  <= acc_nxt;
      wi_r   <= wi_nxt;
      bl_r   <= bl_nxt;
      cnt_r  <= cnt_nxt;
      if (cfg_valid && cfg_ready) cap_r <= cfg_data;
      if (em) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    pd_r  <= pd_nxt;
    pl_r  <= pl_nxt;
    ctl_r <= ctl_nxt;
    if (em) begin
      os_r  <= es;
      od_r  <= ed;
      osi_r <= esi;
      ofa_r <= fill_nxt;
      ol_r  <= el;
    end
  end

  for (genvar g = 0; g < BUF_DEPTH; g++) begin : g_cell
    lbbe_cell #(.IDX(g)) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .prev_byte ((g == 0) ? 8'd0 : cells[(g == 0) ? 0 : g - 1]),
      .cell_byte (cells[g])
    );
  end
endmodule

@@ rtl/lbbe_checker.sv @@
// port-level checks for the linear byte buffer engine
// depends only on the top level's ports; bound below
module lbbe_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_status,
  input logic [7:0] out_data_out,
  input logic [6:0] out_start_index,
  input logic       out_last_result
);
  // refused requests give a single status result with no data
  a_refused: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_data_out == 8'd0 && out_last_result)
    else $error("refused result carries data or is not last");

  // a reserve index only comes on a done single result
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_start_index != 7'd0 |-> out_last_result && !out_status)
    else $error("start index on wrong result");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data_out))
    else $error("stalled result changed");
endmodule

bind linear_byte_buffer_engine_core lbbe_checker u_lbbe_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_status      (out_status),
  .out_data_out    (out_data_out),
  .out_start_index (out_start_index),
  .out_last_result (out_last_result)
);
